@@ rtl/core/ackifg_pkg.sv @@
package ackifg_pkg;

  // Field widths fixed by the frame record and the result word.
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned TIME_BITS     = 48;
  localparam int unsigned TYPE_W        = 8;
  localparam int unsigned LEN_W         = 14;
  localparam int unsigned RATE_W        = 8;
  localparam int unsigned GAP_W         = TIME_BITS + 1;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned MEAN_W        = 24;
  localparam int unsigned SUM_W         = TIME_BITS;

  // Airtime is (length << AIR_SHIFT) / (rate * RATE_SCALE).
  localparam int unsigned AIR_SHIFT  = 18;
  localparam int unsigned RATE_SCALE = 15625;
  localparam int unsigned AIR_W      = 19;

  // Shared serial divider.
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  // The mean divides sum << FRACTION_BITS by the count; the upper part of that
  // dividend preloads the remainder, the low MEAN_LOW_W bits are shifted in.
  localparam int unsigned MEAN_LOW_W = MEAN_W - FRACTION_BITS;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_GAP_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = CFG_IDX_W'(1);

  localparam logic [TYPE_W-1:0]    ACK_TYPE_RESET = TYPE_W'(29);
  localparam logic [MAX_GAP_W-1:0] MAX_GAP_RESET  = MAX_GAP_W'(100);

  typedef struct packed {
    logic [TYPE_W-1:0]    frame_type;
    logic [TIME_BITS-1:0] end_time;
    logic [LEN_W-1:0]     frame_length;
    logic [RATE_W-1:0]    rate_half_mbps;
  } in_word_t;

  typedef struct packed {
    logic signed [GAP_W-1:0] gap_us;
    logic                    gap_counted;
    logic [COUNT_W-1:0]      ack_total;
    logic [MEAN_W-1:0]       mean_gap;
    logic                    rate_zero;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/ackifg_stream_if.sv @@
interface ackifg_in_if;
  logic                 valid;
  logic                 ready;
  ackifg_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ackifg_out_if;
  logic                  valid;
  logic                  ready;
  ackifg_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ackifg_sdiv.sv @@
module ackifg_sdiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ackifg_pkg::div_req_t req_i,
  output ackifg_pkg::div_rsp_t rsp_o
);
  import ackifg_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q, num_q, den_q, quot_q;

  logic [DIV_W:0]   shifted, trial;
  logic             fits;
  logic [DIV_W-1:0] rem_d;

  // One restoring step per cycle: bring down the next dividend bit and
  // subtract the divisor if it fits.
  always_comb begin
    shifted = {rem_q, num_q[DIV_W-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = ~trial[DIV_W];
    rem_d   = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[DIV_W-2:0], 1'b0};
      quot_q <= {quot_q[DIV_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/core/ack_interframe_gap_averager.sv @@
// Frames are handled one at a time: a new frame word is taken only once the
// result word of the previous frame is in the output register, so a full
// output register stalls the next frame. The shared bit-serial divider runs
// 32 steps for the airtime and, unless the mean needs no division, 24 steps
// for the mean.
// Reset (rst_ni, asynchronous, active low) clears the previous end time, the
// count and the sum, and loads ack_type_code = 29 and max_gap_us = 100.
module ack_interframe_gap_averager (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ackifg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ackifg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ackifg_in_if.sink                           in_i,
  ackifg_out_if.source                        out_o
);
  import ackifg_pkg::*;

  // Sequencer states. Each frame goes through them in order (S_MEAN only when
  // the mean is divided), then to idle once its result is in the output register.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a frame word
  localparam logic [2:0] S_AIR  = 3'd1;  // airtime division running
  localparam logic [2:0] S_GAP  = 3'd2;  // gap subtract and count decision
  localparam logic [2:0] S_UPD  = 3'd3;  // count and sum update
  localparam logic [2:0] S_MSET = 3'd4;  // mean special cases, divider start
  localparam logic [2:0] S_MEAN = 3'd5;  // mean division running
  localparam logic [2:0] S_FIN  = 3'd6;  // waiting for the output register

  localparam int unsigned CALC_W = TIME_BITS + 2;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [TYPE_W-1:0]    ack_type_q;
  logic [MAX_GAP_W-1:0] max_gap_q;

  // Running state.
  logic [TIME_BITS-1:0] prev_end_q;
  logic [COUNT_W-1:0]   count_q;
  logic [SUM_W-1:0]     sum_q;

  // Per-frame working registers.
  logic [TYPE_W-1:0]    type_q;
  logic [TIME_BITS-1:0] end_q;
  logic                 rate_zero_q;
  logic [AIR_W-1:0]     air_q;
  logic [GAP_W-1:0]     gap_q;
  logic                 counted_q;
  logic [MEAN_W-1:0]    mean_q;

  // Output register.
  logic      out_valid_q;
  out_word_t out_word_q;

  logic     accept, load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [CALC_W-1:0] diff_w, gap_w;
  logic [GAP_W-1:0]         gap_sat;
  logic                     count_it;
  logic [SUM_W:0]           sum_w;
  logic [COUNT_W-1:0]       sum_hi;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // A finished word goes to the output register once that register is free or
  // is being emptied in the same cycle.
  assign load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // Gap = end - previous end - airtime. With nonnegative airtime only the low
  // end can overflow; that shows as the top two bits reading 10 and clamps to
  // the most negative gap.
  always_comb begin
    diff_w  = $signed({2'b00, end_q}) - $signed({2'b00, prev_end_q});
    gap_w   = diff_w - $signed(CALC_W'(air_q));
    gap_sat = (gap_w[CALC_W-1] && !gap_w[CALC_W-2]) ? {1'b1, {TIME_BITS{1'b0}}}
                                                     : gap_w[GAP_W-1:0];
    count_it = (type_q == ack_type_q) && !gap_sat[GAP_W-1] &&
               (gap_sat[TIME_BITS-1:0] <= TIME_BITS'(max_gap_q)) &&
               (count_q != {COUNT_W{1'b1}});
  end

  assign sum_w  = {1'b0, sum_q} + {1'b0, gap_q[TIME_BITS-1:0]};
  assign sum_hi = sum_q[SUM_W-1:MEAN_LOW_W];

  // Divider requests. The airtime divides the length shifted up by the
  // scale exponent by rate times the scale constant. The mean preloads the
  // upper bits of the sum as the remainder and shifts the rest in, so the
  // quotient is floor(sum * 2^FRACTION_BITS / count) in MEAN_W steps.
  always_comb begin
    div_req = '0;
    if (accept) begin
      div_req.start    = 1'b1;
      div_req.rem_init = '0;
      div_req.num      = DIV_W'(in_i.data.frame_length) << AIR_SHIFT;
      div_req.den      = DIV_W'(in_i.data.rate_half_mbps) * DIV_W'(RATE_SCALE);
      div_req.steps    = STEP_W'(DIV_W);
    end else if (state_q == S_MSET && count_q != '0 && sum_hi < count_q) begin
      div_req.start    = 1'b1;
      div_req.rem_init = DIV_W'(sum_hi);
      div_req.num      = DIV_W'(sum_q[MEAN_LOW_W-1:0]) << (DIV_W - MEAN_LOW_W);
      div_req.den      = DIV_W'(count_q);
      div_req.steps    = STEP_W'(MEAN_W);
    end
  end

  ackifg_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_AIR;
      S_AIR:  if (div_rsp.done) state_d = S_GAP;
      S_GAP:  state_d = S_UPD;
      S_UPD:  state_d = S_MSET;
      S_MSET: state_d = div_req.start ? S_MEAN : S_FIN;
      S_MEAN: if (div_rsp.done) state_d = S_FIN;
      S_FIN:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ack_type_q  <= ACK_TYPE_RESET;
      max_gap_q   <= MAX_GAP_RESET;
      prev_end_q  <= '0;
      count_q     <= '0;
      sum_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACK_TYPE: ack_type_q <= cfg_data_i[TYPE_W-1:0];
          CFG_MAX_GAP:  max_gap_q  <= cfg_data_i[MAX_GAP_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_GAP) begin
        prev_end_q <= end_q;
      end
      if (state_q == S_UPD && counted_q) begin
        count_q <= count_q + COUNT_W'(1);
        sum_q   <= sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q      <= in_i.data.frame_type;
      end_q       <= in_i.data.end_time;
      rate_zero_q <= (in_i.data.rate_half_mbps == '0);
    end
    if (state_q == S_AIR && div_rsp.done) begin
      air_q <= rate_zero_q ? '0 : div_rsp.quot[AIR_W-1:0];
    end
    if (state_q == S_GAP) begin
      gap_q     <= gap_sat;
      counted_q <= count_it;
    end
    if (state_q == S_MSET) begin
      // No count yet means a zero mean; a quotient too large for the field
      // saturates without running the divider.
      mean_q <= (count_q == '0) ? '0 : {MEAN_W{1'b1}};
    end
    if (state_q == S_MEAN && div_rsp.done) begin
      mean_q <= div_rsp.quot[MEAN_W-1:0];
    end
    if (load) begin
      out_word_q.gap_us      <= $signed(gap_q);
      out_word_q.gap_counted <= counted_q;
      out_word_q.ack_total   <= count_q;
      out_word_q.mean_gap    <= mean_q;
      out_word_q.rate_zero   <= rate_zero_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

@@ sim/gap_average_checker.sv @@
module gap_average_checker
  import ackifg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ackifg_in_if                  frames_i,
  ackifg_out_if                 results_i,
  output int unsigned           errors_o,
  output int unsigned           due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GAP_HI = (64'sd1 <<< TIME_BITS) - 1;
  localparam longint GAP_LO = -GAP_HI - 1;
  localparam longint unsigned SUM_LIMIT  = (64'd1 << SUM_W) - 1;
  localparam longint unsigned MEAN_LIMIT = (64'd1 << MEAN_W) - 1;

  logic [TYPE_W-1:0]    ack_code;
  logic [MAX_GAP_W-1:0] gap_limit;
  logic [TIME_BITS-1:0] last_end;
  logic [COUNT_W-1:0]   gaps_counted;
  logic [SUM_W-1:0]     gap_total;

  out_word_t reports_due[$];
  out_word_t want;

  // Works out the report for one frame and moves the running state on.
  function automatic out_word_t next_gap_report(input in_word_t f);
    longint unsigned air, quo, rmd, mean, sum;
    longint diff, gap;
    logic hit;
    out_word_t r;
    air = (f.rate_half_mbps == '0) ? 64'd0 :
          (64'(f.frame_length) << AIR_SHIFT) / (64'(f.rate_half_mbps) * RATE_SCALE);
    diff = longint'(f.end_time) - longint'(last_end);
    if (diff < GAP_LO + longint'(air)) gap = GAP_LO;
    else gap = diff - longint'(air);
    if (gap > GAP_HI) gap = GAP_HI;

    hit = (f.frame_type == ack_code) && (gap >= 0) && (gap <= longint'(gap_limit)) &&
          (gaps_counted != '1);
    if (hit) begin
      gaps_counted = gaps_counted + COUNT_W'(1);
      sum = 64'(gap_total) + 64'(gap);
      gap_total = (sum > SUM_LIMIT) ? '1 : sum[SUM_W-1:0];
    end
    last_end = f.end_time;

    if (gaps_counted == '0) begin
      mean = 0;
    end else begin
      quo = 64'(gap_total) / 64'(gaps_counted);
      rmd = 64'(gap_total) % 64'(gaps_counted);
      if (quo > (MEAN_LIMIT >> FRACTION_BITS)) begin
        mean = MEAN_LIMIT;
      end else begin
        mean = (quo << FRACTION_BITS) + ((rmd << FRACTION_BITS) / 64'(gaps_counted));
        if (mean > MEAN_LIMIT) mean = MEAN_LIMIT;
      end
    end

    r.gap_us      = gap[GAP_W-1:0];
    r.gap_counted = hit;
    r.ack_total   = gaps_counted;
    r.mean_gap    = mean[MEAN_W-1:0];
    r.rate_zero   = (f.rate_half_mbps == '0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_code     = ACK_TYPE_RESET;
      gap_limit    = MAX_GAP_RESET;
      last_end     = '0;
      gaps_counted = '0;
      gap_total    = '0;
      reports_due.delete();
      errors_o     = 0;
      due_o        = 0;
    end else begin
      // A report leaves before the frame of the same edge could produce one.
      if (results_i.valid === 1'b1 && results_i.ready === 1'b1) begin
        if (reports_due.size() == 0) begin
          if (errors_o < 10) begin
            $display("chk: %0t report with nothing outstanding: gap %0d", $realtime,
                     $signed(results_i.data.gap_us));
          end
          errors_o++;
        end else begin
          want = reports_due.pop_front();
          if (results_i.data !== want) begin
            if (errors_o < 10) begin
              $display("chk: %0t mismatch gap %0d/%0d counted %0b/%0b total %0d/%0d",
                       $realtime, $signed(want.gap_us), $signed(results_i.data.gap_us),
                       want.gap_counted, results_i.data.gap_counted,
                       want.ack_total, results_i.data.ack_total);
              $display("chk:   mean %0d/%0d rate_zero %0b/%0b (expected/actual)",
                       want.mean_gap, results_i.data.mean_gap,
                       want.rate_zero, results_i.data.rate_zero);
            end
            errors_o++;
          end
        end
      end
      if (frames_i.valid === 1'b1 && frames_i.ready === 1'b1) begin
        reports_due.push_back(next_gap_report(frames_i.data));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACK_TYPE: ack_code  = cfg_data_i[TYPE_W-1:0];
          CFG_MAX_GAP:  gap_limit = cfg_data_i[MAX_GAP_W-1:0];
          default: ;
        endcase
      end
      due_o = reports_due.size();
    end
  end

endmodule

@@ sim/ack_interframe_gap_averager_tb.sv @@
module ack_interframe_gap_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ackifg_pkg::*;

  // Extra idle time once every outstanding report has arrived.
  localparam int unsigned SETTLE_CYCLES   = 70;
  // Long enough for the block to fill up and push back on the frame channel.
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned PHASE_FRAMES    = 387;
  localparam int unsigned PHASES          = 5;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ackifg_in_if  frame_if ();
  ackifg_out_if report_if ();

  int unsigned mismatches;
  int unsigned reports_due;

  // While calm is set neither side inserts idle cycles. The hold-off request is
  // raised by the stimulus and served, and cleared, by the report receiver.
  logic calm;
  logic hold_out;

  // Stimulus-side copy of the filter settings and of the last end time, used to
  // build frames whose gap lands where we want it.
  logic [TYPE_W-1:0]    ack_code;
  logic [MAX_GAP_W-1:0] gap_limit;
  logic [TIME_BITS-1:0] last_end;
  int unsigned          frames_sent;
  int unsigned          settings_used;

  ack_interframe_gap_averager dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (frame_if),
    .out_o      (report_if)
  );

  gap_average_checker gap_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .frames_i   (frame_if),
    .results_i  (report_if),
    .errors_o   (mismatches),
    .due_o      (reports_due)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Airtime in microseconds as the block computes it; a zero rate gives none.
  function automatic longint unsigned airtime_us(input logic [LEN_W-1:0] len,
                                                 input logic [RATE_W-1:0] rate);
    return (rate == '0) ? 64'd0 : (64'(len) << AIR_SHIFT) / (64'(rate) * RATE_SCALE);
  endfunction

  function automatic in_word_t frame_word(input logic [TYPE_W-1:0] kind,
                                          input logic [TIME_BITS-1:0] stamp,
                                          input logic [LEN_W-1:0] len,
                                          input logic [RATE_W-1:0] rate);
    in_word_t w;
    w.frame_type     = kind;
    w.end_time       = stamp;
    w.frame_length   = len;
    w.rate_half_mbps = rate;
    return w;
  endfunction

  // Builds a frame whose start lies exactly 'gap' microseconds after the end of
  // the previous frame. The end time wraps at the time stamp width.
  function automatic in_word_t gap_frame(input logic [TYPE_W-1:0] kind, input longint gap,
                                         input logic [LEN_W-1:0] len,
                                         input logic [RATE_W-1:0] rate);
    logic [63:0] stamp;
    stamp = 64'(last_end) + airtime_us(len, rate) + 64'(gap);
    return frame_word(kind, stamp[TIME_BITS-1:0], len, rate);
  endfunction

  // Mostly well-formed ACK traffic with gaps inside the window, so the count and
  // the mean keep moving. Some miss: a gap past the window, a negative gap or
  // another type. The rest is noise with every field random, shaking the time base.
  function automatic in_word_t random_frame();
    int unsigned           pick;
    longint                gap;
    logic [LEN_W-1:0]      len;
    logic [RATE_W-1:0]     rate;
    logic [TYPE_W-1:0]     other;
    pick  = $urandom_range(0, 99);
    len   = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 1600));
    rate  = ($urandom_range(0, 19) == 0) ? '0 : RATE_W'($urandom_range(1, 255));
    other = ack_code ^ TYPE_W'($urandom_range(1, 255));
    if (pick < 70) begin
      case ($urandom_range(0, 9))
        0:       gap = 0;
        1:       gap = gap_limit;
        default: gap = $urandom_range(0, gap_limit);
      endcase
      return gap_frame(ack_code, gap, len, rate);
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0:       return gap_frame(ack_code, longint'(gap_limit) + 1, len, rate);
        1:       return gap_frame(ack_code, -longint'($urandom_range(1, 500)), len, rate);
        default: return gap_frame(other, $urandom_range(0, gap_limit), len, rate);
      endcase
    end
    return frame_word(TYPE_W'($urandom), {16'($urandom), 32'($urandom)}, LEN_W'($urandom),
                      RATE_W'($urandom));
  endfunction

  // Offers one word and returns at the falling edge after it was taken. Now and
  // then the sender idles first; the idle length spans a whole processing
  // interval so the gaps fall on every phase of the block's work.
  task automatic send_frame(input in_word_t word);
    if (!calm && $urandom_range(0, 9) == 0) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 70)) @(negedge clk);
    end
    frame_if.valid <= 1'b1;
    frame_if.data  <= word;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    @(negedge clk);
    last_end = word.end_time;
    frames_sent++;
  endtask

  // Stops offering and waits until every outstanding report has arrived, then
  // lets the block settle.
  task automatic wait_for_results();
    frame_if.valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_ack_filter(input logic [TYPE_W-1:0] kind,
                                input logic [MAX_GAP_W-1:0] limit);
    write_reg(CFG_ACK_TYPE, CFG_DATA_W'(kind));
    write_reg(CFG_MAX_GAP, CFG_DATA_W'(limit));
    ack_code  = kind;
    gap_limit = limit;
    settings_used++;
  endtask

  // Report receiver. It drops ready at random with a probability of 6 percent, not at
  // all while calm is set, and serves a hold-off request by keeping ready low for a
  // counted stretch.
  initial begin
    report_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        report_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      report_if.ready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  // Upper bound on the run; a correct run finishes well inside it.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned n;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    frame_if.valid = 1'b0;
    frame_if.data  = '0;
    calm           = 1'b0;
    hold_out       = 1'b0;
    ack_code       = ACK_TYPE_RESET;
    gap_limit      = MAX_GAP_RESET;
    last_end       = '0;
    frames_sent    = 0;
    settings_used  = 1;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the reset filter (ACK code, 100 us window).
    // The first frame is measured from time zero.
    send_frame(frame_word(ack_code, TIME_BITS'(50), '0, RATE_W'(2)));
    // A zero rate means no airtime, even for the longest frame.
    send_frame(gap_frame(ack_code, 30, '1, '0));
    // Longest airtime (longest frame at the lowest rate), gap right at the limit.
    send_frame(gap_frame(ack_code, 100, '1, RATE_W'(1)));
    // Just past the limit, then exactly zero, then a start before the previous end.
    send_frame(gap_frame(ack_code, 101, LEN_W'(1), '1));
    send_frame(gap_frame(ack_code, 0, '1, '1));
    send_frame(gap_frame(ack_code, -1, LEN_W'(200), RATE_W'(11)));
    // Good gaps on frames of other types are never counted.
    send_frame(gap_frame('0, 5, LEN_W'(14), RATE_W'(2)));
    send_frame(gap_frame('1, 5, LEN_W'(14), RATE_W'(4)));
    // Time stamp extremes: back to zero, then the largest positive gap, then a
    // start so far below zero that the gap saturates low.
    send_frame(frame_word(ack_code, '0, '0, '0));
    send_frame(frame_word(ack_code, '1, '0, '0));
    send_frame(frame_word(ack_code, '0, '1, RATE_W'(1)));
    // Previous end is zero, so the gap is minus the airtime.
    send_frame(frame_word(ack_code, '0, '1, RATE_W'(1)));
    send_frame(gap_frame(ack_code, 7, '0, '0));
    send_frame(frame_word(ack_code, TIME_BITS'(48'h8000_0000_0000), LEN_W'(8192),
                          RATE_W'(128)));
    send_frame(gap_frame(ack_code, 64, LEN_W'(9000), RATE_W'(22)));
    send_frame(gap_frame(ack_code, 1, '1, '1));
    wait_for_results();

    // Random part, one filter setting per phase, the extremes among them.
    for (phase_no = 0; phase_no < PHASES; phase_no++) begin
      case (phase_no)
        0:       set_ack_filter('0, '0);
        1:       set_ack_filter('1, '1);
        2:       set_ack_filter(TYPE_W'($urandom_range(1, 254)),
                                MAX_GAP_W'($urandom_range(1, 65534)));
        3:       set_ack_filter(ACK_TYPE_RESET, MAX_GAP_RESET);
        default: set_ack_filter(TYPE_W'(8'hD4), MAX_GAP_W'(2000));
      endcase
      for (n = 0; n < PHASE_FRAMES; n++) begin
        // Stall the report side for a long while and keep offering frames.
        if (phase_no == 0 && n == 40) hold_out = 1'b1;
        // A long stretch with no idling on either side.
        calm = (phase_no == 1) && (n < 200);
        // Pause the frames until every report is in, in the middle of a phase.
        if (phase_no == 3 && n == 150) wait_for_results();
        send_frame(random_frame());
      end
      wait_for_results();
    end

    $display("tb: %0d frames sent over %0d ACK filter settings, one %0d-cycle report stall",
             frames_sent, settings_used, HOLD_OFF_CYCLES);
    $display("tb: directed time stamp and rate extremes, ACK runs, near misses and noise");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ackifg_pkg.sv
rtl/core/ackifg_stream_if.sv
rtl/core/ackifg_sdiv.sv
rtl/core/ack_interframe_gap_averager.sv
sim/gap_average_checker.sv
sim/ack_interframe_gap_averager_tb.sv
